>>> hw/rtl/assert_macros.svh
// Concurrent assertion helpers. They expect signals named clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/hidkbd_pkg.sv
package hidkbd_pkg;

    localparam int DEVICES_DEFAULT = 4;
    localparam int SLOTS           = 6;
    localparam int EVENTS          = 2 * SLOTS;
    localparam int EVENT_IDX_W     = $clog2(EVENTS);

    // Left shift and right shift in the modifier byte.
    localparam logic [7:0] SHIFT_MASK = 8'h22;

    localparam logic [7:0] USAGE_NONE   = 8'h00;
    localparam logic [7:0] USAGE_A      = 8'h04;
    localparam logic [7:0] USAGE_Z      = 8'h1D;
    localparam logic [7:0] USAGE_1      = 8'h1E;
    localparam logic [7:0] USAGE_0      = 8'h27;
    localparam logic [7:0] USAGE_ENTER  = 8'h28;
    localparam logic [7:0] USAGE_ESC    = 8'h29;
    localparam logic [7:0] USAGE_BSPACE = 8'h2A;
    localparam logic [7:0] USAGE_TAB    = 8'h2B;
    localparam logic [7:0] USAGE_SPACE  = 8'h2C;
    localparam logic [7:0] USAGE_MINUS  = 8'h2D;
    localparam logic [7:0] USAGE_EQUAL  = 8'h2E;
    localparam logic [7:0] USAGE_RIGHT  = 8'h4F;
    localparam logic [7:0] USAGE_LEFT   = 8'h50;
    localparam logic [7:0] USAGE_DOWN   = 8'h51;
    localparam logic [7:0] USAGE_UP     = 8'h52;

    localparam logic [7:0] CODE_NONE   = 8'd0;
    localparam logic [7:0] CODE_ENTER  = 8'd128;
    localparam logic [7:0] CODE_ESC    = 8'd129;
    localparam logic [7:0] CODE_BSPACE = 8'd130;
    localparam logic [7:0] CODE_TAB    = 8'd131;
    localparam logic [7:0] CODE_RIGHT  = 8'd132;
    localparam logic [7:0] CODE_LEFT   = 8'd133;
    localparam logic [7:0] CODE_DOWN   = 8'd134;
    localparam logic [7:0] CODE_UP     = 8'd135;

    localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
    localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_MINUS     = 8'h2D;
    localparam logic [7:0] CHAR_UNDERLINE = 8'h5F;
    localparam logic [7:0] CHAR_EQUAL     = 8'h3D;
    localparam logic [7:0] CHAR_PLUS      = 8'h2B;

    // "1234567890" and its shifted row "!@#$%^&*()".
    localparam logic [7:0] DIGIT_CHARS [10] = '{
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30
    };
    localparam logic [7:0] SYMBOL_CHARS [10] = '{
        8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29
    };

    typedef struct packed {
        logic [1:0] device_index;
        logic [7:0] modifiers;
        logic [7:0] key_slot_0;
        logic [7:0] key_slot_1;
        logic [7:0] key_slot_2;
        logic [7:0] key_slot_3;
        logic [7:0] key_slot_4;
        logic [7:0] key_slot_5;
    } report_t;

    typedef struct packed {
        logic [1:0] source_device;
        logic       released;
        logic [7:0] key_code;
        logic [7:0] usage_code;
        logic       last_event;
    } key_event_t;

    typedef logic [SLOTS-1:0][7:0] slots_t;

    // All events one report can cause: key-downs in the low half, key-ups in the high half.
    typedef struct packed {
        logic                        valid;
        logic [1:0]                  device;
        logic [EVENTS-1:0]           mask;
        logic [EVENTS-1:0][7:0]      code;
        logic [EVENTS-1:0][7:0]      usage;
    } batch_t;

    function automatic logic [7:0] usage_to_code(input logic [7:0] usage, input logic shift);
        logic [3:0] idx;
        logic [7:0] code;
        idx  = '0;
        code = CODE_NONE;
        if (usage inside {[USAGE_A:USAGE_Z]}) begin
            code = (shift ? CHAR_UPPER_A : CHAR_LOWER_A) + (usage - USAGE_A);
        end
        else if (usage inside {[USAGE_1:USAGE_0]}) begin
            idx  = 4'(usage - USAGE_1);
            code = shift ? SYMBOL_CHARS[idx] : DIGIT_CHARS[idx];
        end
        else begin
            case (usage)
                USAGE_ENTER:  code = CODE_ENTER;
                USAGE_ESC:    code = CODE_ESC;
                USAGE_BSPACE: code = CODE_BSPACE;
                USAGE_TAB:    code = CODE_TAB;
                USAGE_SPACE:  code = CHAR_SPACE;
                USAGE_MINUS:  code = shift ? CHAR_UNDERLINE : CHAR_MINUS;
                USAGE_EQUAL:  code = shift ? CHAR_PLUS : CHAR_EQUAL;
                USAGE_RIGHT:  code = CODE_RIGHT;
                USAGE_LEFT:   code = CODE_LEFT;
                USAGE_DOWN:   code = CODE_DOWN;
                USAGE_UP:     code = CODE_UP;
                default:      code = CODE_NONE;
            endcase
        end
        return code;
    endfunction

endpackage

>>> hw/rtl/hidkbd_stream_if.sv
interface hidkbd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/hidkbd_event_queue.sv
module hidkbd_event_queue
    import hidkbd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  batch_t batch,
    output logic   batch_ready,
    hidkbd_stream_if.source key_event
);

    logic [EVENTS-1:0]      pend_reg, pend_next;
    logic [1:0]             dev_reg;
    logic [EVENTS-1:0][7:0] code_reg;
    logic [EVENTS-1:0][7:0] usage_reg;
    logic                   out_valid_reg, out_valid_next;
    key_event_t             out_reg, out_next;

    logic [EVENT_IDX_W-1:0] pick;
    logic [EVENTS-1:0]      rest;
    logic                   has_pend;
    logic                   out_free;
    logic                   pop;
    logic                   load;

    always_comb
    begin
        pick = '0;
        for (int k = EVENTS - 1; k >= 0; k--)
        begin
            if (pend_reg[k])
            begin
                pick = EVENT_IDX_W'(k);
            end
        end
    end

    // Clearing the lowest set bit leaves the events still to go after this beat.
    assign rest        = pend_reg & (pend_reg - EVENTS'(1));
    assign has_pend    = |pend_reg;
    assign out_free    = !out_valid_reg || key_event.ready;
    assign pop         = has_pend && out_free;
    assign batch_ready = !has_pend || (pop && (rest == '0));
    assign load        = batch.valid && batch_ready;

    always_comb
    begin
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (load)
        begin
            pend_next = batch.mask;
        end
        else if (pop)
        begin
            pend_next = rest;
        end
        if (pop)
        begin
            out_valid_next         = 1'b1;
            out_next.source_device = dev_reg;
            out_next.released      = (pick >= EVENT_IDX_W'(SLOTS));
            out_next.key_code      = code_reg[pick];
            out_next.usage_code    = usage_reg[pick];
            out_next.last_event    = (rest == '0);
        end
        else if (key_event.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (load)
        begin
            dev_reg   <= batch.device;
            code_reg  <= batch.code;
            usage_reg <= batch.usage;
        end
    end

    assign key_event.valid   = out_valid_reg;
    assign key_event.payload = out_reg;

endmodule

>>> hw/rtl/hid_keyboard_report_key_events.sv
// Boot-protocol keyboard report decoder. Each report beat on report names a device and
// carries a modifier byte and six key usages; the block compares them with that device's
// previous six usages, kept in a small synchronous memory, and sends one beat on key_event
// per key-down (new usages, slot order) and then per key-up (vanished usages, mapped with the
// current shift state), with last_event set on the final beat of the report. Usages that map
// to no code are stored but give no beat. An accepted report is registered with its memory
// read; the next stage builds the event set, writes the new usages back and loads the set
// into the event queue, whose single output register sends one event per cycle while
// key_event.ready allows. A new set loads as the last event of the set before it is taken;
// reports with no events pass at one per cycle while none are pending. Each device entry
// has a valid bit cleared at reset, so usages read as zero after reset with no clearing pass.
`include "assert_macros.svh"

module hid_keyboard_report_key_events
    import hidkbd_pkg::*;
#(
    parameter int DEVICES = DEVICES_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    hidkbd_stream_if.sink   report,
    hidkbd_stream_if.source key_event
);

    localparam int ADDR_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;

    slots_t              mem [DEVICES];
    logic [DEVICES-1:0]  ent_vld_reg;

    logic                s1_valid_reg;
    report_t             s1_item_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    logic                s1_in_range_reg;
    slots_t              rd_data_reg;
    logic                rd_vld_reg;
    logic                fwd_hit_reg;
    slots_t              fwd_data_reg;

    logic                in_fire;
    logic [ADDR_W-1:0]   rd_addr;
    logic                in_range;
    logic                s1_adv;
    logic                wr_en;
    slots_t              wr_data;
    logic                same_entry;

    slots_t              now_keys;
    slots_t              prev_keys;
    logic                shift;
    batch_t              batch;
    logic                batch_ready;

    assign in_fire      = report.valid && report.ready;
    assign rd_addr      = ADDR_W'(report.payload.device_index);
    assign in_range     = int'(report.payload.device_index) < DEVICES;
    assign s1_adv       = s1_valid_reg && batch_ready;
    assign report.ready = !s1_valid_reg || s1_adv;

    assign now_keys = {s1_item_reg.key_slot_5, s1_item_reg.key_slot_4,
                       s1_item_reg.key_slot_3, s1_item_reg.key_slot_2,
                       s1_item_reg.key_slot_1, s1_item_reg.key_slot_0};
    assign wr_en      = s1_adv && s1_in_range_reg;
    assign wr_data    = now_keys;
    assign same_entry = wr_en && (s1_addr_reg == rd_addr);

    // A read issued in the same cycle as the write-back to that entry takes the new usages.
    assign prev_keys = fwd_hit_reg ? fwd_data_reg : (rd_vld_reg ? rd_data_reg : '0);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s1_addr_reg] <= wr_data;
        end
        if (in_fire)
        begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= wr_data;
            s1_item_reg  <= report.payload;
            s1_addr_reg  <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_vld_reg     <= '0;
            s1_valid_reg    <= 1'b0;
            s1_in_range_reg <= 1'b0;
            rd_vld_reg      <= 1'b0;
            fwd_hit_reg     <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                ent_vld_reg[s1_addr_reg] <= 1'b1;
            end
            if (in_fire)
            begin
                s1_valid_reg    <= 1'b1;
                s1_in_range_reg <= in_range;
                rd_vld_reg      <= ent_vld_reg[rd_addr];
                fwd_hit_reg     <= same_entry;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        logic       hit_prev;
        logic       hit_now;
        logic [7:0] down_code;
        logic [7:0] up_code;
        shift        = |(s1_item_reg.modifiers & SHIFT_MASK);
        batch        = '0;
        batch.valid  = s1_valid_reg;
        batch.device = s1_item_reg.device_index;
        for (int i = 0; i < SLOTS; i++)
        begin
            hit_prev = 1'b0;
            hit_now  = 1'b0;
            for (int j = 0; j < SLOTS; j++)
            begin
                hit_prev = hit_prev | (prev_keys[j] == now_keys[i]);
                hit_now  = hit_now | (now_keys[j] == prev_keys[i]);
            end
            down_code = usage_to_code(now_keys[i], shift);
            up_code   = usage_to_code(prev_keys[i], shift);
            batch.code[i]          = down_code;
            batch.usage[i]         = now_keys[i];
            batch.mask[i]          = s1_in_range_reg && (now_keys[i] != USAGE_NONE) &&
                                     !hit_prev && (down_code != CODE_NONE);
            batch.code[SLOTS+i]    = up_code;
            batch.usage[SLOTS+i]   = prev_keys[i];
            batch.mask[SLOTS+i]    = s1_in_range_reg && (prev_keys[i] != USAGE_NONE) &&
                                     !hit_now && (up_code != CODE_NONE);
        end
    end

    hidkbd_event_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .batch       (batch),
        .batch_ready (batch_ready),
        .key_event   (key_event)
    );

    `ASSERT_NEXT(a_fwd_same_entry, in_fire && same_entry, prev_keys == $past(wr_data), "stale usages after back-to-back reports")
    `ASSERT_IMPLIES(a_stage_hold, s1_valid_reg && !s1_adv, !in_fire, "report overwrote a waiting report")
    `ASSERT_NEXT(a_one_device_per_report, key_event.valid && key_event.ready && !key_event.payload.last_event, !key_event.valid || (key_event.payload.source_device == $past(key_event.payload.source_device)), "events of one report mixed devices")

endmodule

>>> bench/hid_keyboard_report_key_events_tb.sv
module hid_keyboard_report_key_events_tb;
    import hidkbd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;

    hidkbd_stream_if #(.payload_t(report_t))    report_bus ();
    hidkbd_stream_if #(.payload_t(key_event_t)) key_bus ();

    hid_keyboard_report_key_events #(
        .DEVICES (DEVICES_DEFAULT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .report    (report_bus),
        .key_event (key_bus)
    );

    // Keeps each keyboard's last six usages and the key events still owed by the block.
    class key_event_tracker;
        slots_t     held_keys [DEVICES_DEFAULT];
        key_event_t owed_events [$];
        int         mismatches;

        function new();
            foreach (held_keys[d])
            begin
                held_keys[d] = '0;
            end
            mismatches = 0;
        endfunction

        function int outstanding();
            return owed_events.size();
        endfunction

        function logic [7:0] key_code_of(input logic [7:0] usage, input logic shift);
            string digit_row;
            string symbol_row;
            digit_row  = "1234567890";
            symbol_row = "!@#$%^&*()";
            if (usage >= USAGE_A && usage <= USAGE_Z)
            begin
                return (shift ? CHAR_UPPER_A : CHAR_LOWER_A) + (usage - USAGE_A);
            end
            if (usage >= USAGE_1 && usage <= USAGE_0)
            begin
                return shift ? symbol_row[usage - USAGE_1] : digit_row[usage - USAGE_1];
            end
            case (usage)
                USAGE_ENTER:  return CODE_ENTER;
                USAGE_ESC:    return CODE_ESC;
                USAGE_BSPACE: return CODE_BSPACE;
                USAGE_TAB:    return CODE_TAB;
                USAGE_SPACE:  return CHAR_SPACE;
                USAGE_MINUS:  return shift ? CHAR_UNDERLINE : CHAR_MINUS;
                USAGE_EQUAL:  return shift ? CHAR_PLUS : CHAR_EQUAL;
                USAGE_RIGHT:  return CODE_RIGHT;
                USAGE_LEFT:   return CODE_LEFT;
                USAGE_DOWN:   return CODE_DOWN;
                USAGE_UP:     return CODE_UP;
                default:      return CODE_NONE;
            endcase
        endfunction

        function bit row_holds(input slots_t row, input logic [7:0] usage);
            for (int i = 0; i < SLOTS; i++)
            begin
                if (row[i] == usage)
                begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // Key-downs come from the new row in slot order, then key-ups from the held row.
        function void note_report(input report_t r);
            slots_t     now_keys;
            slots_t     old_keys;
            slots_t     scan;
            slots_t     other;
            logic       shift;
            logic [7:0] usage;
            logic [7:0] code;
            key_event_t found [EVENTS];
            int         count;
            now_keys = {r.key_slot_5, r.key_slot_4, r.key_slot_3,
                        r.key_slot_2, r.key_slot_1, r.key_slot_0};
            old_keys = held_keys[r.device_index];
            shift    = (r.modifiers & SHIFT_MASK) != 8'h00;
            count    = 0;
            for (int k = 0; k < EVENTS; k++)
            begin
                scan  = (k < SLOTS) ? now_keys : old_keys;
                other = (k < SLOTS) ? old_keys : now_keys;
                usage = scan[k % SLOTS];
                code  = key_code_of(usage, shift);
                if (usage != USAGE_NONE && !row_holds(other, usage) && code != CODE_NONE)
                begin
                    found[count].source_device = r.device_index;
                    found[count].released      = (k >= SLOTS);
                    found[count].key_code      = code;
                    found[count].usage_code    = usage;
                    found[count].last_event    = 1'b0;
                    count++;
                end
            end
            if (count > 0)
            begin
                found[count - 1].last_event = 1'b1;
            end
            for (int k = 0; k < count; k++)
            begin
                owed_events.push_back(found[k]);
            end
            held_keys[r.device_index] = now_keys;
        endfunction

        task flag_mismatch(input string what);
            // Output is capped so that a badly broken block cannot flood the log.
            if (mismatches < 40)
            begin
                $display("%0t ns: key event beat: %s", $time, what);
            end
            mismatches++;
        endtask

        task check_event(input key_event_t got);
            key_event_t want;
            if (owed_events.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected beat usage %02h", got.usage_code));
                return;
            end
            want = owed_events.pop_front();
            if (got.source_device !== want.source_device)
            begin
                flag_mismatch($sformatf("source_device %0d, want %0d",
                                        got.source_device, want.source_device));
            end
            if (got.released !== want.released)
            begin
                flag_mismatch($sformatf("released %0b, want %0b", got.released, want.released));
            end
            if (got.key_code !== want.key_code)
            begin
                flag_mismatch($sformatf("key_code %02h, want %02h", got.key_code, want.key_code));
            end
            if (got.usage_code !== want.usage_code)
            begin
                flag_mismatch($sformatf("usage_code %02h, want %02h",
                                        got.usage_code, want.usage_code));
            end
            if (got.last_event !== want.last_event)
            begin
                flag_mismatch($sformatf("last_event %0b, want %0b",
                                        got.last_event, want.last_event));
            end
        endtask
    endclass

    key_event_tracker events_tracker = new();

    slots_t last_sent [DEVICES_DEFAULT];
    int     sender_idle_pct;
    int     receiver_idle_pct;
    bit     long_stall_request;
    bit     long_stall_taken;
    int     stall_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver side; a requested long hold-off is counted down here.
    initial
    begin
        key_bus.ready    <= 1'b0;
        stall_left       = 0;
        long_stall_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_stall_request && !long_stall_taken)
            begin
                long_stall_taken = 1'b1;
                stall_left       = 300;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                key_bus.ready <= 1'b0;
            end
            else
            begin
                key_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (report_bus.valid && report_bus.ready)
            begin
                events_tracker.note_report(report_bus.payload);
            end
            if (key_bus.valid && key_bus.ready)
            begin
                events_tracker.check_event(key_bus.payload);
            end
        end
    end

    function automatic report_t compose_report(input logic [1:0] dev, input logic [7:0] mods,
                                               input slots_t keys);
        report_t r;
        r.device_index = dev;
        r.modifiers    = mods;
        {r.key_slot_5, r.key_slot_4, r.key_slot_3,
         r.key_slot_2, r.key_slot_1, r.key_slot_0} = keys;
        return r;
    endfunction

    function automatic logic [7:0] random_usage();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            return USAGE_A + 8'($urandom_range(0, USAGE_EQUAL - USAGE_A));
        end
        if (pick < 90)
        begin
            return USAGE_RIGHT + 8'($urandom_range(0, 3));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly a plausible next report for one keyboard: keys stay held, new ones go down,
    // some come up. The rest is raw noise, a full release or a repeat of the last report.
    function automatic report_t next_report();
        int     dev;
        int     style;
        slots_t keys;
        dev   = $urandom_range(0, DEVICES_DEFAULT - 1);
        style = $urandom_range(0, 99);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (style < 75)
            begin
                case ($urandom_range(0, 3))
                    0, 1:    keys[i] = last_sent[dev][i];
                    2:       keys[i] = random_usage();
                    default: keys[i] = USAGE_NONE;
                endcase
            end
            else if (style < 90)
            begin
                keys[i] = 8'($urandom);
            end
            else
            begin
                keys[i] = (style < 95) ? USAGE_NONE : last_sent[dev][i];
            end
        end
        return compose_report(2'(dev), 8'($urandom), keys);
    endfunction

    task automatic send_report(input report_t r);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            report_bus.valid <= 1'b0;
            @(posedge clk);
        end
        report_bus.valid   <= 1'b1;
        report_bus.payload <= r;
        @(posedge clk);
        while (!report_bus.ready)
        begin
            @(posedge clk);
        end
        last_sent[r.device_index] = {r.key_slot_5, r.key_slot_4, r.key_slot_3,
                                     r.key_slot_2, r.key_slot_1, r.key_slot_0};
    endtask

    task automatic drain_events();
        report_bus.valid <= 1'b0;
        while (events_tracker.outstanding() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            send_report(next_report());
        end
    endtask

    initial
    begin
        rst_n                <= 1'b0;
        report_bus.valid     <= 1'b0;
        report_bus.payload   <= '0;
        long_stall_request   = 1'b0;
        foreach (last_sent[d])
        begin
            last_sent[d] = '0;
        end
        sender_idle_pct   = 8;
        receiver_idle_pct = 84;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Slots are listed from slot 5 down to slot 0.
        send_report(compose_report(2'd0, 8'h00, {8'h29, 8'h28, 8'h27, 8'h1E, 8'h1D, 8'h04}));
        // Left shift; all six keys change, so six key-downs and six shifted key-ups.
        send_report(compose_report(2'd0, 8'h02, {8'h4F, 8'h2E, 8'h2D, 8'h2C, 8'h2B, 8'h2A}));
        send_report(compose_report(2'd0, 8'h20, {8'h2D, 8'h1E, 8'h04, 8'h52, 8'h51, 8'h50}));
        // The same keys in the same slots, shift bits clear: nothing changes.
        send_report(compose_report(2'd0, 8'hDD, {8'h2D, 8'h1E, 8'h04, 8'h52, 8'h51, 8'h50}));
        send_report(compose_report(2'd0, 8'hFF, '0));
        // Unmapped usages are stored but never announced.
        send_report(compose_report(2'd1, 8'h00, {8'h4E, 8'h2F, 8'h03, 8'h53, 8'h80, 8'hFF}));
        send_report(compose_report(2'd1, 8'h00, {8'h2F, 8'h03, 8'h53, 8'h80, 8'hFF, 8'h04}));
        send_report(compose_report(2'd1, 8'h00, '0));
        // A usage repeated across slots gives one beat per slot.
        send_report(compose_report(2'd2, 8'h02, {8'h00, 8'h00, 8'h05, 8'h04, 8'h04, 8'h04}));
        send_report(compose_report(2'd2, 8'h00, {8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}));
        send_report(compose_report(2'd3, 8'h00, {8'h00, 8'h00, 8'h00, 8'h00, 8'h2D, 8'h2E}));
        send_report(compose_report(2'd3, 8'h22, {8'h00, 8'h00, 8'h00, 8'h00, 8'h2E, 8'h2D}));
        send_report(compose_report(2'd3, 8'h22, '0));
        send_report(compose_report(2'd2, 8'hAA, '0));
        send_report(compose_report(2'd0, 8'h55, {8'hF0, 8'h0F, 8'h02, 8'h01, 8'hC0, 8'h7F}));
        send_report(compose_report(2'd3, 8'h00, {8'h00, 8'h00, 8'h00, 8'h00, 8'h27, 8'h1D}));
        send_report(compose_report(2'd1, 8'h00, '0));
        send_report(compose_report(2'd3, 8'h80, {8'h52, 8'h51, 8'h50, 8'h4F, 8'h2C, 8'h29}));

        send_random(130);
        drain_events();

        sender_idle_pct   = 84;
        receiver_idle_pct = 8;
        send_random(130);
        drain_events();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        // The receiver holds off while reports keep coming, so the input backs up.
        long_stall_request = 1'b1;
        send_random(40);
        send_random(80);

        drain_events();
        repeat (20) @(posedge clk);
        if (events_tracker.mismatches == 0 && events_tracker.outstanding() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/hidkbd_pkg.sv
hw/rtl/hidkbd_stream_if.sv
hw/rtl/hidkbd_event_queue.sv
hw/rtl/hid_keyboard_report_key_events.sv
bench/hid_keyboard_report_key_events_tb.sv
